@@ design/cpd_pkg.sv @@
// ----------------------------------------------------------------------------
// cpd_pkg
// shared constants, types and helpers of the cyclic prefix peak detector
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int unsigned MAX_SYMBOL_LENGTH  = 1024;
  localparam int unsigned MAX_PREFIX_LENGTH  = 64;
  localparam int unsigned SAMPLE_STORE_DEPTH = 2048;
  localparam int unsigned SAMPLE_BITS        = 12;

  // register widths
  localparam int unsigned SYM_W   = 11;
  localparam int unsigned PFX_W   = 7;
  localparam int unsigned POWER_W = 57;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned CFG_W   = 57;

  // datapath widths
  localparam int unsigned STORE_AW = $clog2(SAMPLE_STORE_DEPTH);
  localparam int unsigned DELAY_AW = $clog2(MAX_PREFIX_LENGTH);
  localparam int unsigned PROD_W   = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W    = PROD_W + DELAY_AW;
  localparam int unsigned SQ_W     = 2 * SUM_W;

  // largest magnitude whose square still fits the power field
  localparam logic [SUM_W-1:0] SQRT_POWER_LIMIT = SUM_W'(379625062);

  // symbol length cap: lesser of the max length and one less than the store depth
  localparam int unsigned SYM_CAP = (MAX_SYMBOL_LENGTH < SAMPLE_STORE_DEPTH - 1) ?
                                    MAX_SYMBOL_LENGTH : SAMPLE_STORE_DEPTH - 1;

  typedef enum logic [1:0] {
    CFG_SYMBOL_LENGTH = 2'd0,
    CFG_PREFIX_LENGTH = 2'd1,
    CFG_UPPER_THRESH  = 2'd2,
    CFG_LOWER_THRESH  = 2'd3
  } cfg_idx_e;

  // per-stage strobes from the sequencer
  typedef struct packed {
    logic acc;
    logic mul;
    logic sum;
    logic sqr;
    logic dec;
    logic clr;
  } stage_t;

  function automatic logic [SYM_W-1:0] eff_symbol(input logic [SYM_W-1:0] n);
    logic [SYM_W-1:0] r;
    r = n;
    if (r == '0) r = SYM_W'(1);
    if (r > SYM_W'(SYM_CAP)) r = SYM_W'(SYM_CAP);
    return r;
  endfunction

  function automatic logic [PFX_W-1:0] eff_prefix(input logic [PFX_W-1:0] l);
    logic [PFX_W-1:0] r;
    r = l;
    if (r == '0) r = PFX_W'(1);
    if (r > PFX_W'(MAX_PREFIX_LENGTH)) r = PFX_W'(MAX_PREFIX_LENGTH);
    return r;
  endfunction

endpackage

@@ design/cpd_ram.sv @@
// ----------------------------------------------------------------------------
// cpd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/cpd_corr.sv @@
// ----------------------------------------------------------------------------
// cpd_corr
// sample store, product delay line and sliding correlation sum
// ----------------------------------------------------------------------------
module cpd_corr (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cpd_pkg::stage_t                     stage_i,
  input  logic signed [cpd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [cpd_pkg::SYM_W-1:0]           sym_len_i,
  input  logic [cpd_pkg::PFX_W-1:0]           pfx_len_i,
  output logic signed [cpd_pkg::SUM_W-1:0]    sum_o
);

  localparam int unsigned SB = cpd_pkg::SAMPLE_BITS;

  logic [cpd_pkg::STORE_AW-1:0]   store_ptr_q, store_ptr_d;
  logic [cpd_pkg::STORE_AW:0]     fill_q, fill_d;
  logic [cpd_pkg::DELAY_AW-1:0]   delay_ptr_q, delay_ptr_d;
  logic [cpd_pkg::MAX_PREFIX_LENGTH-1:0] dvld_q, dvld_d;
  logic                           past_vld_q, past_vld_d;
  logic                           old_vld_q, old_vld_d;
  logic signed [SB-1:0]           x_q, x_d;
  logic signed [cpd_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [cpd_pkg::SUM_W-1:0]  sum_q, sum_d;

  logic [cpd_pkg::STORE_AW-1:0]   store_raddr;
  logic [cpd_pkg::DELAY_AW-1:0]   delay_raddr;
  logic [SB-1:0]                  past_raw;
  logic [cpd_pkg::PROD_W-1:0]     old_raw;
  logic signed [SB-1:0]           past;
  logic signed [cpd_pkg::PROD_W-1:0] old_prod;

  assign store_raddr = store_ptr_q - cpd_pkg::STORE_AW'(sym_len_i);
  assign delay_raddr = delay_ptr_q - pfx_len_i[cpd_pkg::DELAY_AW-1:0];

  cpd_ram #(
    .WIDTH (SB),
    .DEPTH (cpd_pkg::SAMPLE_STORE_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (stage_i.acc),
    .waddr_i (store_ptr_q),
    .wdata_i (sample_i),
    .re_i    (stage_i.acc),
    .raddr_i (store_raddr),
    .rdata_o (past_raw)
  );

  cpd_ram #(
    .WIDTH (cpd_pkg::PROD_W),
    .DEPTH (cpd_pkg::MAX_PREFIX_LENGTH)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (stage_i.sum),
    .waddr_i (delay_ptr_q),
    .wdata_i (prod_q),
    .re_i    (stage_i.acc),
    .raddr_i (delay_raddr),
    .rdata_o (old_raw)
  );

  // samples unwritten since reset, and products unwritten since reset or a length change, read as zero
  assign past     = past_vld_q ? signed'(past_raw) : '0;
  assign old_prod = old_vld_q ? signed'(old_raw) : '0;

  always_comb begin
    store_ptr_d = store_ptr_q;
    fill_d      = fill_q;
    delay_ptr_d = delay_ptr_q;
    dvld_d      = dvld_q;
    past_vld_d  = past_vld_q;
    old_vld_d   = old_vld_q;
    x_d         = x_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    if (stage_i.acc) begin
      x_d         = sample_i;
      past_vld_d  = (fill_q >= (cpd_pkg::STORE_AW + 1)'(sym_len_i));
      old_vld_d   = dvld_q[delay_raddr];
      store_ptr_d = store_ptr_q + 1'b1;
      if (fill_q != (cpd_pkg::STORE_AW + 1)'(cpd_pkg::SAMPLE_STORE_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (stage_i.mul) begin
      prod_d = x_q * past;
    end
    if (stage_i.sum) begin
      sum_d               = sum_q + cpd_pkg::SUM_W'(prod_q) - cpd_pkg::SUM_W'(old_prod);
      dvld_d[delay_ptr_q] = 1'b1;
      delay_ptr_d         = delay_ptr_q + 1'b1;
    end
    if (stage_i.clr) begin
      sum_d  = '0;
      dvld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_ptr_q <= '0;
      fill_q      <= '0;
      delay_ptr_q <= '0;
      dvld_q      <= '0;
      past_vld_q  <= 1'b0;
      old_vld_q   <= 1'b0;
      sum_q       <= '0;
    end else begin
      store_ptr_q <= store_ptr_d;
      fill_q      <= fill_d;
      delay_ptr_q <= delay_ptr_d;
      dvld_q      <= dvld_d;
      past_vld_q  <= past_vld_d;
      old_vld_q   <= old_vld_d;
      sum_q       <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    prod_q <= prod_d;
  end

  assign sum_o = sum_q;

endmodule

@@ design/cpd_peak.sv @@
// ----------------------------------------------------------------------------
// cpd_peak
// squares the correlation and tracks the peak between the two thresholds
// ----------------------------------------------------------------------------
module cpd_peak (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cpd_pkg::stage_t                   stage_i,
  input  logic signed [cpd_pkg::SUM_W-1:0]  sum_i,
  input  logic [cpd_pkg::POS_W-1:0]         pos_i,
  input  logic [cpd_pkg::PFX_W-1:0]         pfx_len_i,
  input  logic [cpd_pkg::POWER_W-1:0]       upper_i,
  input  logic [cpd_pkg::POWER_W-1:0]       lower_i,
  output logic                              fire_o,
  output logic [cpd_pkg::POS_W-1:0]         start_o,
  output logic [cpd_pkg::POWER_W-1:0]       power_o
);

  logic [cpd_pkg::SUM_W-1:0]   mag;
  logic [cpd_pkg::SQ_W-1:0]    sq;
  logic [cpd_pkg::POWER_W-1:0] power_q, power_d;
  logic                        armed_q, armed_d;
  logic [cpd_pkg::POWER_W-1:0] best_q, best_d;
  logic [cpd_pkg::POS_W-1:0]   bpos_q, bpos_d;
  logic                        hit_up, upd, armed_n;
  logic [cpd_pkg::POWER_W-1:0] best_n;
  logic [cpd_pkg::POS_W-1:0]   bpos_n;

  assign mag = sum_i[cpd_pkg::SUM_W-1] ? cpd_pkg::SUM_W'(-sum_i) : cpd_pkg::SUM_W'(sum_i);
  assign sq  = mag * mag;

  assign power_d = !stage_i.sqr ? power_q :
                   (mag > cpd_pkg::SQRT_POWER_LIMIT) ? '1 : sq[cpd_pkg::POWER_W-1:0];

  // decision on the registered power
  assign hit_up  = (power_q >= upper_i);
  assign armed_n = armed_q | hit_up;
  assign upd     = hit_up && (best_q <= power_q);
  assign best_n  = upd ? power_q : best_q;
  assign bpos_n  = upd ? pos_i : bpos_q;
  assign fire_o  = armed_n && (power_q < lower_i);
  assign start_o = bpos_n + cpd_pkg::POS_W'(pfx_len_i);
  assign power_o = best_n;

  always_comb begin
    armed_d = armed_q;
    best_d  = best_q;
    bpos_d  = bpos_q;
    if (stage_i.dec) begin
      if (fire_o) begin
        armed_d = 1'b0;
        best_d  = '0;
        bpos_d  = '0;
      end else begin
        armed_d = armed_n;
        best_d  = best_n;
        bpos_d  = bpos_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      best_q  <= '0;
      bpos_q  <= '0;
    end else begin
      armed_q <= armed_d;
      best_q  <= best_d;
      bpos_q  <= bpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    power_q <= power_d;
  end

endmodule

@@ design/cyclic_prefix_peak_detector.sv @@
// ----------------------------------------------------------------------------
// cyclic_prefix_peak_detector
// coarse ofdm symbol timing from cyclic prefix correlation
// ----------------------------------------------------------------------------
// Each request on the sample stream carries one signed 12-bit sample. The block
// correlates it with the sample one symbol length earlier, keeps a sliding sum
// of the last prefix-length products and squares it. While that power stays at
// or above the upper threshold it tracks the largest power and its prefix
// position (later position wins ties); when power drops below the lower
// threshold it sends one result request with symbol start = peak position plus
// prefix length and the peak power. An item passes in order through sample and
// product memory read, multiply, window add and delay write, square and peak
// decision. The decision waits while the result register still holds a result
// not yet taken downstream. Results are held in an output register, so a new
// sample is taken while a result waits. Writing the symbol or prefix length
// clears the window sum and the product delay line; the sample memory needs no
// clearing pass after reset, a fill count marks its unwritten entries as zero.
// Configuration must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module cyclic_prefix_peak_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [56:0] cfg_data_i,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] rx_sample
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // [31:0] symbol_start, [88:32] peak_power
);

  // one-hot item sequencer
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUM  = 5'b00100,
    S_SQR  = 5'b01000,
    S_DEC  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [cpd_pkg::SYM_W-1:0]   sym_len_q, sym_len_d;
  logic [cpd_pkg::PFX_W-1:0]   pfx_len_q, pfx_len_d;
  logic [cpd_pkg::POWER_W-1:0] upper_q, upper_d;
  logic [cpd_pkg::POWER_W-1:0] lower_q, lower_d;
  logic                        len_wr;

  logic [cpd_pkg::SYM_W-1:0]   n_eff;
  logic [cpd_pkg::PFX_W-1:0]   l_eff;

  // sample counter and prefix position of the item in flight
  logic [cpd_pkg::POS_W-1:0]   count_q, count_d;
  logic [cpd_pkg::POS_W-1:0]   pos_q, pos_d;

  // result register
  logic                        out_vld_q, out_vld_d;
  logic [cpd_pkg::POS_W-1:0]   out_start_q, out_start_d;
  logic [cpd_pkg::POWER_W-1:0] out_power_q, out_power_d;

  cpd_pkg::stage_t             stage;
  logic                        in_acc;
  logic                        dec_go;
  logic signed [cpd_pkg::SUM_W-1:0] win_sum;
  logic                        fire;
  logic [cpd_pkg::POS_W-1:0]   res_start;
  logic [cpd_pkg::POWER_W-1:0] res_power;

  assign n_eff = cpd_pkg::eff_symbol(sym_len_q);
  assign l_eff = cpd_pkg::eff_prefix(pfx_len_q);

  // ---------------------------------------------------------------- config
  always_comb begin
    sym_len_d = sym_len_q;
    pfx_len_d = pfx_len_q;
    upper_d   = upper_q;
    lower_d   = lower_q;
    len_wr    = 1'b0;
    if (cfg_we_i) begin
      unique case (cpd_pkg::cfg_idx_e'(cfg_idx_i))
        cpd_pkg::CFG_SYMBOL_LENGTH: begin
          sym_len_d = cfg_data_i[cpd_pkg::SYM_W-1:0];
          len_wr    = 1'b1;
        end
        cpd_pkg::CFG_PREFIX_LENGTH: begin
          pfx_len_d = cfg_data_i[cpd_pkg::PFX_W-1:0];
          len_wr    = 1'b1;
        end
        cpd_pkg::CFG_UPPER_THRESH: upper_d = cfg_data_i[cpd_pkg::POWER_W-1:0];
        cpd_pkg::CFG_LOWER_THRESH: lower_d = cfg_data_i[cpd_pkg::POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------- sequencer
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  // decision only once the result register can take a new result
  assign dec_go        = (state_q == S_DEC) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_MUL;
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = S_SQR;
      S_SQR:  state_d = S_DEC;
      S_DEC:  if (dec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign stage.acc = in_acc;
  assign stage.mul = (state_q == S_MUL);
  assign stage.sum = (state_q == S_SUM);
  assign stage.sqr = (state_q == S_SQR);
  assign stage.dec = dec_go;
  assign stage.clr = len_wr;

  // prefix position p = count - N - L + 1, wraps modulo 2^32
  assign count_d = in_acc ? count_q + 1'b1 : count_q;
  assign pos_d   = in_acc ? count_q - cpd_pkg::POS_W'(n_eff) - cpd_pkg::POS_W'(l_eff) + 1'b1
                          : pos_q;

  // ------------------------------------------------------------- datapath
  cpd_corr u_corr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .sample_i  (s_axis_tdata[cpd_pkg::SAMPLE_BITS-1:0]),
    .sym_len_i (n_eff),
    .pfx_len_i (l_eff),
    .sum_o     (win_sum)
  );

  cpd_peak u_peak (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .sum_i     (win_sum),
    .pos_i     (pos_q),
    .pfx_len_i (l_eff),
    .upper_i   (upper_q),
    .lower_i   (lower_q),
    .fire_o    (fire),
    .start_o   (res_start),
    .power_o   (res_power)
  );

  // ------------------------------------------------------- result register
  always_comb begin
    out_vld_d   = out_vld_q;
    out_start_d = out_start_q;
    out_power_d = out_power_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (dec_go && fire) begin
      out_vld_d   = 1'b1;
      out_start_d = res_start;
      out_power_d = res_power;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_power_q, out_start_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sym_len_q <= cpd_pkg::SYM_W'(64);
      pfx_len_q <= cpd_pkg::PFX_W'(16);
      upper_q   <= cpd_pkg::POWER_W'(1);
      lower_q   <= cpd_pkg::POWER_W'(1);
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sym_len_q <= sym_len_d;
      pfx_len_q <= pfx_len_d;
      upper_q   <= upper_d;
      lower_q   <= lower_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    out_start_q <= out_start_d;
    out_power_q <= out_power_d;
  end

  // ------------------------------------------------------------ assertions
  // one sample at a time: no new request right after one is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("sample taken while previous item still in flight");

  // a new result appears only from a peak decision
  a_res_from_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(dec_go && fire))
    else $error("result raised without a peak decision");

  // a length write empties the correlation window
  a_len_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_wr |=> (win_sum == '0))
    else $error("window sum not cleared after length write");

  // a pending untaken result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !dec_go)
    else $error("decision taken while result register busy");

endmodule
